FILE: hdl/tlc_pkg.sv
// ---------------------------------------------------------------------------
// Two-level cache model package
// Shared types and register indexes for the cache model core.
// ---------------------------------------------------------------------------
package tlc_pkg;

    typedef enum logic [1:0] {
        CFG_BLOCK_OFFSET = 2'd0,
        CFG_L1_SET_BITS  = 2'd1,
        CFG_L2_SET_BITS  = 2'd2,
        CFG_WRITE_ALLOC  = 2'd3
    } t_cfg_idx;

    // One classified access travelling from the front to the back.
    typedef struct packed {
        logic [31:0] blk;
        logic        is_write;
    } t_req;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_READ  = 2'd1,
        ST_EXEC  = 2'd2,
        ST_CLEAR = 2'd3
    } t_state;

endpackage

FILE: hdl/tlc_front.sv
// ---------------------------------------------------------------------------
// Cache model front end
// Accepts accesses, drops the block offset and queues them for the back end.
// ---------------------------------------------------------------------------
module tlc_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [31:0]        i_address,
    input  logic               i_is_write,
    input  logic [3:0]         i_offset_bits,
    output logic               o_req_valid,
    input  logic               i_req_pop,
    output tlc_pkg::t_req      o_req
);
    // Two-entry queue.
    tlc_pkg::t_req r_q [2];
    logic          r_wp, r_rp;
    logic [1:0]    r_cnt;
    logic          w_push, w_pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign w_push      = i_valid && o_ready;
    assign w_pop       = i_req_pop && (r_cnt != 2'd0);
    assign o_req_valid = (r_cnt != 2'd0);
    assign o_req       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) r_wp <= ~r_wp;
            if (w_pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, w_push} - {1'b0, w_pop};
        end
        if (w_push) begin
            r_q[r_wp].blk      <= i_address >> i_offset_bits;
            r_q[r_wp].is_write <= i_is_write;
        end
    end
endmodule

FILE: hdl/tlc_back.sv
// ---------------------------------------------------------------------------
// Cache model back end
// Looks up both levels, updates lines and counters, and holds the result.
// ---------------------------------------------------------------------------
module tlc_back #(
    parameter int L1_SETS = 64,
    parameter int L1_WAYS = 2,
    parameter int L2_SETS = 256,
    parameter int L2_WAYS = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_req_valid,
    output logic          o_req_pop,
    input  tlc_pkg::t_req i_req,
    input  logic [2:0]    i_l1_bits,
    input  logic [3:0]    i_l2_bits,
    input  logic          i_wr_alloc,
    output logic          o_valid,
    input  logic          i_ready,
    output logic [161:0]  o_data
);
    localparam int S1W = (L1_SETS > 1) ? $clog2(L1_SETS) : 1;
    localparam int S2W = (L2_SETS > 1) ? $clog2(L2_SETS) : 1;
    localparam int L1MAX = $clog2(L1_SETS + 1) - 1;
    localparam int L2MAX = $clog2(L2_SETS + 1) - 1;
    localparam int W1W = (L1_WAYS > 1) ? $clog2(L1_WAYS) : 1;
    localparam int W2W = (L2_WAYS > 1) ? $clog2(L2_WAYS) : 1;
    localparam int E1 = 1 + 32 + 32 + 1;  // valid, tag, stamp, dirty
    localparam int E2 = 1 + 32 + 32 + 1;
    localparam int NCLR = (L1_SETS > L2_SETS) ? L1_SETS : L2_SETS;
    localparam int CLW = (NCLR > 1) ? $clog2(NCLR) : 1;

    // One row per set; each row holds every way with its valid bit.
    // A clearing pass after reset zeroes every row.
    logic [L1_WAYS*E1-1:0] m_l1 [L1_SETS];
    logic [L2_WAYS*E2-1:0] m_l2 [L2_SETS];
    logic [L1_WAYS*E1-1:0] r_row1;
    logic [L2_WAYS*E2-1:0] r_row2;

    tlc_pkg::t_state r_st, n_st;
    logic [31:0] r_cnt [5];
    logic [31:0] r_tag1, r_tag2;
    logic [S1W-1:0] r_set1;
    logic [S2W-1:0] r_set2;
    logic        r_wr;
    logic        r_ov;
    logic [CLW-1:0] r_clr;

    logic [3:0]  w_b1, w_b2;
    logic [31:0] w_mask1, w_mask2;
    always_comb begin
        w_b1 = (32'(i_l1_bits) > 32'(L1MAX)) ? 4'(L1MAX) : {1'b0, i_l1_bits};
        w_b2 = (32'(i_l2_bits) > 32'(L2MAX)) ? 4'(L2MAX) : i_l2_bits;
        w_mask1 = ~(32'hFFFF_FFFF << w_b1);
        w_mask2 = ~(32'hFFFF_FFFF << w_b2);
    end

    // Execute-stage decisions.
    logic [31:0] w_now;
    logic [L1_WAYS-1:0] w_v1;
    logic [L2_WAYS-1:0] w_v2;
    logic        w_h1, w_h2, w_fill;
    logic [W1W-1:0] w_hw1, w_vic1, w_w1;
    logic [W2W-1:0] w_hw2, w_vic2, w_w2;
    logic        w_f1;
    logic [31:0] w_best1, w_best2;

    always_comb begin
        w_now = r_cnt[4] + 32'd1;
        for (int w = 0; w < L1_WAYS; w++) w_v1[w] = r_row1[w*E1+65];
        for (int w = 0; w < L2_WAYS; w++) w_v2[w] = r_row2[w*E2+65];
        w_h1 = 1'b0; w_hw1 = '0;
        for (int w = L1_WAYS-1; w >= 0; w--)
            if (w_v1[w] && r_row1[w*E1+33 +: 32] == r_tag1) begin
                w_h1 = 1'b1; w_hw1 = W1W'(w);
            end
        w_h2 = 1'b0; w_hw2 = '0;
        for (int w = L2_WAYS-1; w >= 0; w--)
            if (w_v2[w] && r_row2[w*E2+33 +: 32] == r_tag2) begin
                w_h2 = 1'b1; w_hw2 = W2W'(w);
            end
        w_vic1 = '0; w_best1 = r_row1[1 +: 32];
        for (int w = 1; w < L1_WAYS; w++)
            if (r_row1[w*E1+1 +: 32] < w_best1) begin
                w_best1 = r_row1[w*E1+1 +: 32]; w_vic1 = W1W'(w);
            end
        for (int w = L1_WAYS-1; w >= 0; w--)
            if (!w_v1[w]) w_vic1 = W1W'(w);
        w_vic2 = '0; w_best2 = r_row2[1 +: 32];
        for (int w = 1; w < L2_WAYS; w++)
            if (r_row2[w*E2+1 +: 32] < w_best2) begin
                w_best2 = r_row2[w*E2+1 +: 32]; w_vic2 = W2W'(w);
            end
        for (int w = L2_WAYS-1; w >= 0; w--)
            if (!w_v2[w]) w_vic2 = W2W'(w);
        w_fill = !r_wr || i_wr_alloc;
        w_f1 = w_h1 || w_h2 || w_fill;
        w_w1 = w_h1 ? w_hw1 : w_vic1;
        w_w2 = w_h2 ? w_hw2 : w_vic2;
    end

    // A new access may start while the held result leaves in the same cycle.
    always_comb begin
        n_st = r_st;
        o_req_pop = 1'b0;
        case (r_st)
            tlc_pkg::ST_IDLE: if (i_req_valid && (!r_ov || i_ready)) begin
                o_req_pop = 1'b1;
                n_st = tlc_pkg::ST_READ;
            end
            tlc_pkg::ST_READ: n_st = tlc_pkg::ST_EXEC;
            tlc_pkg::ST_EXEC: n_st = tlc_pkg::ST_IDLE;
            tlc_pkg::ST_CLEAR: if (32'(r_clr) == 32'(NCLR - 1)) begin
                n_st = tlc_pkg::ST_IDLE;
            end
            default: n_st = tlc_pkg::ST_IDLE;
        endcase
    end

    logic [31:0] w_blk_s1, w_blk_s2;
    assign w_blk_s1 = i_req.blk & w_mask1;
    assign w_blk_s2 = i_req.blk & w_mask2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st  <= tlc_pkg::ST_CLEAR;
            r_clr <= '0;
            r_ov  <= 1'b0;
            for (int k = 0; k < 5; k++) r_cnt[k] <= '0;
        end else begin
            r_st <= n_st;
            if (r_st == tlc_pkg::ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (o_valid && i_ready) r_ov <= 1'b0;
            if (r_st == tlc_pkg::ST_EXEC) begin
                r_ov <= 1'b1;
                r_cnt[4] <= w_now;
                if (w_h1) r_cnt[0] <= r_cnt[0] + 32'd1;
                else r_cnt[1] <= r_cnt[1] + 32'd1;
                if (!w_h1 && w_h2) r_cnt[2] <= r_cnt[2] + 32'd1;
                if (!w_h1 && !w_h2) r_cnt[3] <= r_cnt[3] + 32'd1;
            end
        end
        if (o_req_pop) begin
            r_set1 <= S1W'(w_blk_s1);
            r_set2 <= S2W'(w_blk_s2);
            r_tag1 <= i_req.blk >> w_b1;
            r_tag2 <= i_req.blk >> w_b2;
            r_wr   <= i_req.is_write;
        end
        if (r_st == tlc_pkg::ST_READ) begin
            r_row1 <= m_l1[r_set1];
            r_row2 <= m_l2[r_set2];
        end
        if (r_st == tlc_pkg::ST_EXEC) begin
            o_data[0] <= w_h1;
            o_data[1] <= !w_h1 && w_h2;
            o_data[33:2]    <= w_h1 ? r_cnt[0] + 32'd1 : r_cnt[0];
            o_data[65:34]   <= w_h1 ? r_cnt[1] : r_cnt[1] + 32'd1;
            o_data[97:66]   <= (!w_h1 && w_h2) ? r_cnt[2] + 32'd1 : r_cnt[2];
            o_data[129:98]  <= (!w_h1 && !w_h2) ? r_cnt[3] + 32'd1 : r_cnt[3];
            o_data[161:130] <= w_now;
        end
    end

    // Row write-back in the execute cycle (memory write port).
    logic [L1_WAYS*E1-1:0] w_nrow1;
    logic [L2_WAYS*E2-1:0] w_nrow2;
    always_comb begin
        w_nrow1 = r_row1;
        w_nrow1[32'(w_w1)*E1+65] = 1'b1;
        w_nrow1[32'(w_w1)*E1+1 +: 32] = w_now;
        if (w_h1) begin
            if (r_wr) w_nrow1[32'(w_w1)*E1] = 1'b1;
        end else begin
            w_nrow1[32'(w_w1)*E1+33 +: 32] = r_tag1;
            w_nrow1[32'(w_w1)*E1] = r_wr;
        end
        w_nrow2 = r_row2;
        w_nrow2[32'(w_w2)*E2+65] = 1'b1;
        w_nrow2[32'(w_w2)*E2+1 +: 32] = w_now;
        if (!w_h2) begin
            w_nrow2[32'(w_w2)*E2+33 +: 32] = r_tag2;
            w_nrow2[32'(w_w2)*E2] = r_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == tlc_pkg::ST_CLEAR) begin
            if (32'(r_clr) < 32'(L1_SETS)) m_l1[r_clr[S1W-1:0]] <= '0;
            if (32'(r_clr) < 32'(L2_SETS)) m_l2[r_clr[S2W-1:0]] <= '0;
        end else if (r_st == tlc_pkg::ST_EXEC) begin
            if (w_f1) m_l1[r_set1] <= w_nrow1;
            if (!w_h1 && (w_h2 || w_fill)) m_l2[r_set2] <= w_nrow2;
        end
    end

    assign o_valid = r_ov;
endmodule

FILE: hdl/two_level_cache_lru_model_core.sv
// ---------------------------------------------------------------------------
// Two-level set-associative cache model with LRU replacement
// Each accepted beat waits in the front-end queue; the back end pops it, reads
// the set rows of both levels, then looks up, writes the rows back and holds
// the result. The back end finishes one access before it pops the next, and
// pops only while no result is held or the held result leaves.
// Reset (synchronous, active low) clears counters and the queue, then a
// clearing pass zeroes the set rows of both levels.
// ---------------------------------------------------------------------------
module two_level_cache_lru_model_core #(
    parameter int L1_SETS = 64,
    parameter int L1_WAYS = 2,
    parameter int L2_SETS = 256,
    parameter int L2_WAYS = 4
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [39:0]  s_axis_tdata,   // address[31:0], is_write[32], zero pad
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // l1_hit, l2_hit, l1_hit_count, l1_miss_count, l2_hit_count,
    // l2_miss_count, access_count, zero pad
    output logic [167:0] m_axis_tdata,
    input  logic         i_cfg_valid,
    output logic         o_cfg_ready,
    input  logic [1:0]   i_cfg_index,
    input  logic [3:0]   i_cfg_data
);
    // Configuration registers; writes are taken at any time.
    logic [3:0] r_off;
    logic [2:0] r_b1;
    logic [3:0] r_b2;
    logic       r_wa;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_off <= 4'd4;
            r_b1  <= 3'd6;
            r_b2  <= 4'd8;
            r_wa  <= 1'b1;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                tlc_pkg::CFG_BLOCK_OFFSET: r_off <= i_cfg_data;
                tlc_pkg::CFG_L1_SET_BITS:  r_b1  <= i_cfg_data[2:0];
                tlc_pkg::CFG_L2_SET_BITS:  r_b2  <= i_cfg_data;
                tlc_pkg::CFG_WRITE_ALLOC:  r_wa  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    tlc_pkg::t_req w_req;
    logic          w_req_valid, w_req_pop;
    logic [161:0]  w_out;

    // Front: accepts beats and queues block addresses.
    tlc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_address     (s_axis_tdata[31:0]),
        .i_is_write    (s_axis_tdata[32]),
        .i_offset_bits (r_off),
        .o_req_valid   (w_req_valid),
        .i_req_pop     (w_req_pop),
        .o_req         (w_req)
    );

    // Back: lookup, fill, LRU stamps and counters.
    tlc_back #(
        .L1_SETS (L1_SETS),
        .L1_WAYS (L1_WAYS),
        .L2_SETS (L2_SETS),
        .L2_WAYS (L2_WAYS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (w_req_valid),
        .o_req_pop   (w_req_pop),
        .i_req       (w_req),
        .i_l1_bits   (r_b1),
        .i_l2_bits   (r_b2),
        .i_wr_alloc  (r_wa),
        .o_valid     (m_axis_tvalid),
        .i_ready     (m_axis_tready),
        .o_data      (w_out)
    );

    assign m_axis_tdata = {6'd0, w_out};
endmodule

FILE: tb/sv/two_level_cache_lru_model_core_tb.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Two-level cache model core testbench
// Drives memory accesses over the input stream, predicts every result beat
// with a behavioral copy of both cache levels, and compares each field.
// ---------------------------------------------------------------------------
module two_level_cache_lru_model_core_tb;

    localparam int L1_SETS = 64;
    localparam int L1_WAYS = 2;
    localparam int L2_SETS = 256;
    localparam int L2_WAYS = 4;

    // One predicted result beat, last member in the lowest bits.
    typedef struct packed {
        logic [31:0] accesses;
        logic [31:0] l2_misses;
        logic [31:0] l2_hits;
        logic [31:0] l1_misses;
        logic [31:0] l1_hits;
        logic        l2_hit;
        logic        l1_hit;
    } t_outcome;

    logic         i_clk;
    logic         i_rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [39:0]  s_axis_tdata;   // address[31:0], is_write[32], zero pad
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    // l1_hit, l2_hit, l1_hit_count, l1_miss_count, l2_hit_count,
    // l2_miss_count, access_count, zero pad
    logic [167:0] m_axis_tdata;
    logic         i_cfg_valid;
    logic         o_cfg_ready;
    logic [1:0]   i_cfg_index;
    logic [3:0]   i_cfg_data;

    two_level_cache_lru_model_core #(
        .L1_SETS(L1_SETS), .L1_WAYS(L1_WAYS), .L2_SETS(L2_SETS), .L2_WAYS(L2_WAYS)
    ) uut (.*);

    // Shadow copy of the block's configuration and cache contents.
    logic [3:0]  offset_bits;
    logic [2:0]  l1_bits;
    logic [3:0]  l2_bits;
    logic        alloc_on_write;
    logic [31:0] l1_tag   [L1_WAYS*L1_SETS];
    logic        l1_valid [L1_WAYS*L1_SETS];
    logic [31:0] l1_stamp [L1_WAYS*L1_SETS];
    logic [31:0] l2_tag   [L2_WAYS*L2_SETS];
    logic        l2_valid [L2_WAYS*L2_SETS];
    logic [31:0] l2_stamp [L2_WAYS*L2_SETS];
    logic [31:0] tally [5];

    t_outcome pending_outcomes[$];
    int       failures;
    int       beats_sent;
    int       beats_checked;
    bit       rx_stall_on;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    initial begin
        #50_000_000;
        $display("Timeout at %0t", $time);
        $display("Verification failed");
        $finish;
    end

    // Dirty bits never reach the outputs, so the shadow copy skips them.
    function automatic int pick_victim(input bit second, input int set, input int ways,
                                       input int sets);
        int victim;
        logic [31:0] oldest;
        victim = 0;
        for (int w = 0; w < ways; w++)
            if (!(second ? l2_valid[w*sets+set] : l1_valid[w*sets+set])) return w;
        oldest = second ? l2_stamp[set] : l1_stamp[set];
        for (int w = 1; w < ways; w++) begin
            if ((second ? l2_stamp[w*sets+set] : l1_stamp[w*sets+set]) < oldest) begin
                oldest = second ? l2_stamp[w*sets+set] : l1_stamp[w*sets+set];
                victim = w;
            end
        end
        return victim;
    endfunction

    function automatic t_outcome predict_access(input logic [31:0] addr, input logic wr);
        t_outcome    res;
        int          b1, b2, set1, set2, w1, w2, v, idx;
        logic [31:0] blk, tag1, tag2, now;
        // Oversized set-bit settings saturate at the number of physical sets.
        b1 = (l1_bits > 6) ? 6 : l1_bits;
        b2 = (l2_bits > 8) ? 8 : l2_bits;
        tally[4] = tally[4] + 1;
        now  = tally[4];
        blk  = addr >> offset_bits;
        set1 = blk & ((32'd1 << b1) - 1);
        set2 = blk & ((32'd1 << b2) - 1);
        tag1 = blk >> b1;
        tag2 = blk >> b2;
        w1 = -1;
        w2 = -1;
        for (int w = L1_WAYS - 1; w >= 0; w--)
            if (l1_valid[w*L1_SETS+set1] && l1_tag[w*L1_SETS+set1] == tag1) w1 = w;
        for (int w = L2_WAYS - 1; w >= 0; w--)
            if (l2_valid[w*L2_SETS+set2] && l2_tag[w*L2_SETS+set2] == tag2) w2 = w;
        res = '0;
        if (w1 >= 0) begin
            // An L1 hit leaves L2 and its counters alone.
            res.l1_hit = 1'b1;
            tally[0] = tally[0] + 1;
            l1_stamp[w1*L1_SETS+set1] = now;
        end else if (w2 >= 0) begin
            // L2 hit always refills L1, even a write without allocation.
            res.l2_hit = 1'b1;
            tally[1] = tally[1] + 1;
            tally[2] = tally[2] + 1;
            l2_stamp[w2*L2_SETS+set2] = now;
            v = pick_victim(1'b0, set1, L1_WAYS, L1_SETS);
            idx = v*L1_SETS + set1;
            l1_tag[idx] = tag1; l1_valid[idx] = 1'b1; l1_stamp[idx] = now;
        end else begin
            if (!wr || alloc_on_write) begin
                v = pick_victim(1'b0, set1, L1_WAYS, L1_SETS);
                idx = v*L1_SETS + set1;
                l1_tag[idx] = tag1; l1_valid[idx] = 1'b1; l1_stamp[idx] = now;
                v = pick_victim(1'b1, set2, L2_WAYS, L2_SETS);
                idx = v*L2_SETS + set2;
                l2_tag[idx] = tag2; l2_valid[idx] = 1'b1; l2_stamp[idx] = now;
            end
            tally[1] = tally[1] + 1;
            tally[3] = tally[3] + 1;
        end
        res.l1_hits   = tally[0];
        res.l1_misses = tally[1];
        res.l2_hits   = tally[2];
        res.l2_misses = tally[3];
        res.accesses  = tally[4];
        return res;
    endfunction

    // Sends one access beat, with an optional random gap in front of it.
    // Valid stays high after the beat; the gap or the next drain lowers it.
    task automatic send_access(input logic [31:0] addr, input logic wr, input bit may_idle);
        if (may_idle && $urandom_range(0, 3) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {7'd0, wr, addr};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        pending_outcomes.push_back(predict_access(addr, wr));
        beats_sent++;
    endtask

    task automatic wait_drained();
        int guard;
        s_axis_tvalid <= 1'b0;
        guard = 0;
        while (pending_outcomes.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (6) @(posedge i_clk);
    endtask

    task automatic write_reg(input tlc_pkg::t_cfg_idx idx, input logic [3:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            tlc_pkg::CFG_BLOCK_OFFSET: offset_bits    = val;
            tlc_pkg::CFG_L1_SET_BITS:  l1_bits        = val[2:0];
            tlc_pkg::CFG_L2_SET_BITS:  l2_bits        = val;
            default:                   alloc_on_write = val[0];
        endcase
    endtask

    task automatic configure(input logic [3:0] ofs, input logic [2:0] b1,
                             input logic [3:0] b2, input logic wa);
        wait_drained();
        write_reg(tlc_pkg::CFG_BLOCK_OFFSET, ofs);
        write_reg(tlc_pkg::CFG_L1_SET_BITS, {1'b0, b1});
        write_reg(tlc_pkg::CFG_L2_SET_BITS, b2);
        write_reg(tlc_pkg::CFG_WRITE_ALLOC, {3'd0, wa});
        i_cfg_valid <= 1'b0;
    endtask

    // Directed: field extremes, hits at each level, write without allocation.
    task automatic test_directed();
        send_access(32'h0000_0000, 1'b0, 1'b0);
        send_access(32'hFFFF_FFFF, 1'b1, 1'b0);
        send_access(32'h0000_0004, 1'b1, 1'b0);
        send_access(32'hFFFF_FFF0, 1'b0, 1'b0);
        // Three tags in one L1 set evict an L1 line that L2 still holds.
        send_access(32'h0001_0000, 1'b0, 1'b0);
        send_access(32'h0002_0000, 1'b0, 1'b0);
        send_access(32'h0003_0000, 1'b0, 1'b0);
        send_access(32'h0001_0000, 1'b1, 1'b0);
        configure(4'd4, 3'd6, 4'd8, 1'b0);
        send_access(32'h1234_5670, 1'b1, 1'b0);
        send_access(32'h1234_5670, 1'b0, 1'b0);
        send_access(32'h0002_0000, 1'b1, 1'b0);
        send_access(32'hAAAA_5555, 1'b1, 1'b0);
        send_access(32'h5555_AAAA, 1'b0, 1'b0);
    endtask

    // Oversized set-bit values must saturate; zero set bits means one set.
    task automatic test_extreme_config();
        configure(4'd15, 3'd7, 4'd15, 1'b1);
        repeat (20) send_access($urandom, $urandom_range(0, 1), 1'b1);
        configure(4'd0, 3'd0, 4'd0, 1'b0);
        repeat (20) send_access($urandom_range(0, 15), $urandom_range(0, 1), 1'b1);
        configure(4'd12, 3'd6, 4'd8, 1'b1);
        repeat (20) send_access($urandom, $urandom_range(0, 1), 1'b1);
    endtask

    // Random accesses over a small working set so hits, evictions and LRU
    // choices all occur; a slice of fully random addresses adds noise.
    task automatic test_random(input int count, input bit may_idle);
        logic [31:0] base;
        logic [31:0] addr;
        base = $urandom;
        for (int n = 0; n < count; n++) begin
            if ($urandom_range(0, 9) == 0) addr = $urandom;
            else addr = base ^ ($urandom_range(0, 31) << offset_bits)
                             ^ ($urandom_range(0, 3) << 20);
            send_access(addr, $urandom_range(0, 1), may_idle);
        end
    endtask

    // Result checker: compares each result beat with the oldest prediction.
    always @(posedge i_clk) begin
        t_outcome got, want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got = m_axis_tdata[161:0];
            if (pending_outcomes.size() == 0) begin
                $display("%0t: unexpected result beat %h", $time, got);
                failures++;
            end else begin
                want = pending_outcomes.pop_front();
                beats_checked++;
                if (got !== want || m_axis_tdata[167:162] !== 6'd0) begin
                    $display("%0t: mismatch expected %h actual %h", $time, want,
                             m_axis_tdata);
                    failures++;
                end
            end
        end
    end

    // Receiver back-pressure: random stall bursts while rx_stall_on is set.
    always @(posedge i_clk) begin
        if (rx_stall_on && $urandom_range(0, 4) == 0) begin
            m_axis_tready <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        m_axis_tready <= 1'b1;
    end

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        m_axis_tready = 1'b1;
        i_cfg_valid = 1'b0;
        i_cfg_index = tlc_pkg::CFG_BLOCK_OFFSET;
        i_cfg_data = '0;
        failures = 0;
        beats_sent = 0;
        beats_checked = 0;
        rx_stall_on = 1'b1;
        offset_bits = 4'd4; l1_bits = 3'd6; l2_bits = 4'd8; alloc_on_write = 1'b1;
        foreach (l1_valid[k]) l1_valid[k] = 1'b0;
        foreach (l2_valid[k]) l2_valid[k] = 1'b0;
        foreach (tally[k]) tally[k] = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        test_extreme_config();
        configure(4'd6, 3'd2, 4'd3, 1'b1);
        test_random(600, 1'b1);
        // Sender holds off until the pipeline has fully drained.
        wait_drained();
        configure(4'd2, 3'd4, 4'd5, 1'b0);
        test_random(600, 1'b1);
        configure(4'd4, 3'd6, 4'd8, 1'b1);
        rx_stall_on = 1'b0;
        test_random(650, 1'b0);

        wait_drained();
        repeat (10) @(posedge i_clk);
        $display("Sent %0d access beats over several register settings, checked %0d results.",
                 beats_sent, beats_checked);
        $display("Covered L1/L2 hits, misses, LRU eviction and write-allocate on and off.");
        if (pending_outcomes.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time,
                     pending_outcomes.size());
            failures++;
        end
        if (failures == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
